[design/jsp_pkg.sv]
// Shared types and constants of the job slot pool.
// Used by the interfaces, controller, datapath, top level and checker.
package jsp_pkg;

	localparam int LINK_W = 7;
	localparam int SLOT_W = 6;
	localparam int TAG_W  = 32;
	localparam int OP_W   = 2;
	localparam int STAT_W = 2;
	localparam int CODE_W = 4;

	localparam logic [LINK_W-1:0] NULL_LINK = 7'd127;

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_WALK    = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL       = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOT_ACTIVE = 2'd3;

	localparam logic [CODE_W-1:0] DP_NONE      = 4'd0;
	localparam logic [CODE_W-1:0] DP_LOAD      = 4'd1;
	localparam logic [CODE_W-1:0] DP_AL_START  = 4'd2;
	localparam logic [CODE_W-1:0] DP_AL_LINK   = 4'd3;
	localparam logic [CODE_W-1:0] DP_AL_BACK   = 4'd4;
	localparam logic [CODE_W-1:0] DP_RL_START  = 4'd5;
	localparam logic [CODE_W-1:0] DP_RL_LINK   = 4'd6;
	localparam logic [CODE_W-1:0] DP_RL_FREE   = 4'd7;
	localparam logic [CODE_W-1:0] DP_WK_START  = 4'd8;
	localparam logic [CODE_W-1:0] DP_WK_STEP   = 4'd9;
	localparam logic [CODE_W-1:0] DP_CLEAR     = 4'd10;
	localparam logic [CODE_W-1:0] DP_SLOT_IDX  = 4'd11;
	localparam logic [CODE_W-1:0] DP_SLOT_ZERO = 4'd12;

	typedef struct packed {
		logic [CODE_W-1:0] code;
		logic              emit;
		logic [STAT_W-1:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic free_ok;
		logic head_ok;
		logic rel_ok;
		logic room;
		logic fin;
	} dp_stat_t;

endpackage

[design/jsp_if.sv]
// Request and response channel interfaces of the job slot pool.
// Depends on jsp_pkg for field widths.
interface jsp_req_if;
	logic                       valid;
	logic                       ready;
	logic [jsp_pkg::OP_W-1:0]   operation;
	logic [jsp_pkg::TAG_W-1:0]  job_tag;
	logic                       has_handler;
	logic [jsp_pkg::SLOT_W-1:0] slot_index;

	modport source (output valid, operation, job_tag, has_handler, slot_index, input ready);
	modport sink (input valid, operation, job_tag, has_handler, slot_index, output ready);
endinterface

interface jsp_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [jsp_pkg::STAT_W-1:0] status;
	logic [jsp_pkg::SLOT_W-1:0] slot_out;
	logic [jsp_pkg::TAG_W-1:0]  tag_out;
	logic                       handler_out;
	logic                       last;

	modport source (output valid, status, slot_out, tag_out, handler_out, last, input ready);
	modport sink (input valid, status, slot_out, tag_out, handler_out, last, output ready);
endinterface

[design/job_slot_pool_with_active_list.sv]
// Job slot pool: a free list and a newest-first doubly linked active list over POOL_SLOTS
// slots. One request is handled at a time; req.ready is high only between requests. Allocate
// passes the start, link and back-link states and release the start, link and free states,
// and the response state then loads the response register; clear and every error response go
// from the start state straight to the response state. A walk reads the head in the start
// state and loads its first slot in the walk state, then one more slot per cycle while rsp
// has room; the last one returns the controller to idle, where the next request is taken. The
// link memories have registered read data and take one link update per memory per cycle. A
// walk or a pending response stalls while rsp is held off. Free-list links that were never
// written read through per-slot valid bits, so no clearing pass follows reset or the clear
// operation. Depends on jsp_pkg, jsp_req_if/jsp_rsp_if, jsp_ctrl and jsp_dp.
module job_slot_pool_with_active_list #(
	parameter int POOL_SLOTS = 64
) (
	input logic    clk,
	input logic    arst_n,
	jsp_req_if.sink   req,
	jsp_rsp_if.source rsp
);

	jsp_pkg::dp_cmd_t  dp_cmd;
	jsp_pkg::dp_stat_t dp_stat;

	jsp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_operation (req.operation),
		.req_ready     (req.ready),
		.dp_stat       (dp_stat),
		.dp_cmd        (dp_cmd)
	);

	jsp_dp #(
		.POOL_SLOTS (POOL_SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.dp_stat     (dp_stat),
		.job_tag     (req.job_tag),
		.has_handler (req.has_handler),
		.slot_index  (req.slot_index),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.status      (rsp.status),
		.slot_out    (rsp.slot_out),
		.tag_out     (rsp.tag_out),
		.handler_out (rsp.handler_out),
		.last        (rsp.last)
	);

endmodule

[design/jsp_ctrl.sv]
// Controller state machine of the job slot pool.
// Sequences datapath commands per operation; depends on jsp_pkg.
module jsp_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic [jsp_pkg::OP_W-1:0]   req_operation,
	output logic                       req_ready,
	input  jsp_pkg::dp_stat_t          dp_stat,
	output jsp_pkg::dp_cmd_t           dp_cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_START   = 3'd1;
	localparam logic [2:0] S_AL_LINK = 3'd2;
	localparam logic [2:0] S_AL_BACK = 3'd3;
	localparam logic [2:0] S_RL_LINK = 3'd4;
	localparam logic [2:0] S_RL_FREE = 3'd5;
	localparam logic [2:0] S_WALK    = 3'd6;
	localparam logic [2:0] S_RESP    = 3'd7;

	logic [2:0]                 state_q, state_d;
	logic [jsp_pkg::OP_W-1:0]   op_q;
	logic [jsp_pkg::STAT_W-1:0] stat_q, stat_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d       = state_q;
		stat_d        = stat_q;
		dp_cmd.code   = jsp_pkg::DP_NONE;
		dp_cmd.emit   = 1'b0;
		dp_cmd.status = stat_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					dp_cmd.code = jsp_pkg::DP_LOAD;
					state_d     = S_START;
				end
			end
			S_START: begin
				unique case (op_q)
					jsp_pkg::OP_ALLOC: begin
						if (dp_stat.free_ok) begin
							dp_cmd.code = jsp_pkg::DP_AL_START;
							state_d     = S_AL_LINK;
						end else begin
							dp_cmd.code = jsp_pkg::DP_SLOT_ZERO;
							stat_d      = jsp_pkg::ST_FULL;
							state_d     = S_RESP;
						end
					end
					jsp_pkg::OP_RELEASE: begin
						if (dp_stat.rel_ok) begin
							dp_cmd.code = jsp_pkg::DP_RL_START;
							state_d     = S_RL_LINK;
						end else begin
							dp_cmd.code = jsp_pkg::DP_SLOT_IDX;
							stat_d      = jsp_pkg::ST_NOT_ACTIVE;
							state_d     = S_RESP;
						end
					end
					jsp_pkg::OP_WALK: begin
						if (dp_stat.head_ok) begin
							dp_cmd.code = jsp_pkg::DP_WK_START;
							state_d     = S_WALK;
						end else begin
							dp_cmd.code = jsp_pkg::DP_SLOT_ZERO;
							stat_d      = jsp_pkg::ST_EMPTY;
							state_d     = S_RESP;
						end
					end
					default: begin
						dp_cmd.code = jsp_pkg::DP_CLEAR;
						stat_d      = jsp_pkg::ST_OK;
						state_d     = S_RESP;
					end
				endcase
			end
			S_AL_LINK: begin
				dp_cmd.code = jsp_pkg::DP_AL_LINK;
				state_d     = S_AL_BACK;
			end
			S_AL_BACK: begin
				dp_cmd.code = jsp_pkg::DP_AL_BACK;
				stat_d      = jsp_pkg::ST_OK;
				state_d     = S_RESP;
			end
			S_RL_LINK: begin
				dp_cmd.code = jsp_pkg::DP_RL_LINK;
				state_d     = S_RL_FREE;
			end
			S_RL_FREE: begin
				dp_cmd.code = jsp_pkg::DP_RL_FREE;
				stat_d      = jsp_pkg::ST_OK;
				state_d     = S_RESP;
			end
			S_WALK: begin
				if (dp_stat.room) begin
					dp_cmd.code   = jsp_pkg::DP_WK_STEP;
					dp_cmd.emit   = 1'b1;
					dp_cmd.status = jsp_pkg::ST_OK;
					if (dp_stat.fin) begin
						state_d = S_IDLE;
					end
				end
			end
			S_RESP: begin
				if (dp_stat.room) begin
					dp_cmd.emit = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stat_q  <= jsp_pkg::ST_OK;
			op_q    <= jsp_pkg::OP_ALLOC;
		end else begin
			state_q <= state_d;
			stat_q  <= stat_d;
			if (req_valid && req_ready) begin
				op_q <= req_operation;
			end
		end
	end

endmodule

[design/jsp_dp.sv]
// Datapath of the job slot pool: link memories, tag store, list heads, output register.
// Executes one command per cycle from jsp_ctrl; depends on jsp_pkg.
module jsp_dp #(
	parameter int POOL_SLOTS = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  jsp_pkg::dp_cmd_t           dp_cmd,
	output jsp_pkg::dp_stat_t          dp_stat,
	input  logic [jsp_pkg::TAG_W-1:0]  job_tag,
	input  logic                       has_handler,
	input  logic [jsp_pkg::SLOT_W-1:0] slot_index,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [jsp_pkg::STAT_W-1:0] status,
	output logic [jsp_pkg::SLOT_W-1:0] slot_out,
	output logic [jsp_pkg::TAG_W-1:0]  tag_out,
	output logic                       handler_out,
	output logic                       last
);

	localparam int IDX_W = $clog2(POOL_SLOTS);
	localparam int LW    = jsp_pkg::LINK_W;
	localparam int TW    = jsp_pkg::TAG_W;
	localparam logic [LW-1:0]    LIMIT    = LW'(POOL_SLOTS);
	localparam logic [IDX_W-1:0] LAST_CNT = IDX_W'(POOL_SLOTS - 1);

	logic [LW-1:0] next_mem [POOL_SLOTS];
	logic [LW-1:0] prev_mem [POOL_SLOTS];
	logic [TW:0]   data_mem [POOL_SLOTS];

	logic [POOL_SLOTS-1:0] init_q;
	logic [POOL_SLOTS-1:0] active_q;
	logic [LW-1:0]         free_head_q;
	logic [LW-1:0]         active_head_q;
	logic                  out_valid_q;

	logic [LW-1:0]                cur_q;
	logic [LW-1:0]                old_q;
	logic [IDX_W-1:0]             cnt_q;
	logic [TW-1:0]                tag_q;
	logic                         hnd_q;
	logic [jsp_pkg::SLOT_W-1:0]   idx_q;
	logic [LW-1:0]                next_rd_q;
	logic [LW-1:0]                prev_rd_q;
	logic [TW:0]                  data_rd_q;
	logic [IDX_W-1:0]             raddr_q;
	logic                         rinit_q;
	logic [jsp_pkg::STAT_W-1:0]   status_q;
	logic [jsp_pkg::SLOT_W-1:0]   slot_q;
	logic [TW-1:0]                tag_out_q;
	logic                         hnd_out_q;
	logic                         last_q;

	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             next_we, prev_we, data_we;
	logic [IDX_W-1:0] next_wa, prev_wa;
	logic [LW-1:0]    next_wd, prev_wd;
	logic [LW-1:0]    dflt_next, nxt;
	logic [IDX_W-1:0] cur_idx;
	logic             room, fin, emit_ok;

	function automatic logic link_ok(input logic [LW-1:0] v);
		return v < LIMIT;
	endfunction

	assign cur_idx   = cur_q[IDX_W-1:0];
	assign dflt_next = link_ok(LW'(raddr_q) + LW'(1)) ? LW'(raddr_q) + LW'(1)
		: jsp_pkg::NULL_LINK;
	assign nxt       = rinit_q ? next_rd_q : dflt_next;
	assign room      = !out_valid_q || out_ready;
	assign fin       = !link_ok(nxt) || (cnt_q == LAST_CNT);
	assign emit_ok   = dp_cmd.emit && room;

	assign dp_stat.free_ok = link_ok(free_head_q);
	assign dp_stat.head_ok = link_ok(active_head_q);
	assign dp_stat.rel_ok  = link_ok({1'b0, idx_q}) && active_q[idx_q[IDX_W-1:0]];
	assign dp_stat.room    = room;
	assign dp_stat.fin     = fin;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_idx;
		next_we = 1'b0;
		next_wa = cur_idx;
		next_wd = active_head_q;
		prev_we = 1'b0;
		prev_wa = cur_idx;
		prev_wd = jsp_pkg::NULL_LINK;
		data_we = 1'b0;
		unique case (dp_cmd.code)
			jsp_pkg::DP_AL_START: begin
				rd_en   = 1'b1;
				rd_addr = free_head_q[IDX_W-1:0];
			end
			jsp_pkg::DP_AL_LINK: begin
				next_we = 1'b1;
				prev_we = 1'b1;
				data_we = 1'b1;
			end
			jsp_pkg::DP_AL_BACK: begin
				prev_we = link_ok(old_q);
				prev_wa = old_q[IDX_W-1:0];
				prev_wd = cur_q;
			end
			jsp_pkg::DP_RL_START: begin
				rd_en   = 1'b1;
				rd_addr = idx_q[IDX_W-1:0];
			end
			jsp_pkg::DP_RL_LINK: begin
				next_we = link_ok(prev_rd_q);
				next_wa = prev_rd_q[IDX_W-1:0];
				next_wd = nxt;
				prev_we = link_ok(nxt);
				prev_wa = nxt[IDX_W-1:0];
				prev_wd = prev_rd_q;
			end
			jsp_pkg::DP_RL_FREE: begin
				next_we = 1'b1;
				next_wd = free_head_q;
				prev_we = 1'b1;
			end
			jsp_pkg::DP_WK_START: begin
				rd_en   = 1'b1;
				rd_addr = active_head_q[IDX_W-1:0];
			end
			jsp_pkg::DP_WK_STEP: begin
				rd_en   = !fin;
				rd_addr = nxt[IDX_W-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (data_we) begin
			data_mem[cur_idx] <= {hnd_q, tag_q};
		end
		if (rd_en) begin
			next_rd_q <= next_mem[rd_addr];
			prev_rd_q <= prev_mem[rd_addr];
			data_rd_q <= data_mem[rd_addr];
			raddr_q   <= rd_addr;
			rinit_q   <= init_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		case (dp_cmd.code)
			jsp_pkg::DP_LOAD: begin
				tag_q <= job_tag;
				hnd_q <= has_handler;
				idx_q <= slot_index;
			end
			jsp_pkg::DP_AL_START: begin
				cur_q <= free_head_q;
			end
			jsp_pkg::DP_AL_LINK: begin
				old_q <= active_head_q;
			end
			jsp_pkg::DP_RL_START, jsp_pkg::DP_SLOT_IDX: begin
				cur_q <= {1'b0, idx_q};
			end
			jsp_pkg::DP_WK_START: begin
				cur_q <= active_head_q;
				cnt_q <= '0;
			end
			jsp_pkg::DP_WK_STEP: begin
				cur_q <= nxt;
				cnt_q <= cnt_q + IDX_W'(1);
			end
			jsp_pkg::DP_CLEAR, jsp_pkg::DP_SLOT_ZERO: begin
				cur_q <= '0;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
		if (emit_ok) begin
			status_q <= dp_cmd.status;
			slot_q   <= cur_q[jsp_pkg::SLOT_W-1:0];
			if (dp_cmd.code == jsp_pkg::DP_WK_STEP) begin
				tag_out_q <= data_rd_q[TW-1:0];
				hnd_out_q <= data_rd_q[TW];
				last_q    <= fin;
			end else begin
				tag_out_q <= '0;
				hnd_out_q <= 1'b0;
				last_q    <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q        <= '0;
			active_q      <= '0;
			free_head_q   <= '0;
			active_head_q <= jsp_pkg::NULL_LINK;
			out_valid_q   <= 1'b0;
		end else begin
			case (dp_cmd.code)
				jsp_pkg::DP_AL_LINK: begin
					free_head_q       <= nxt;
					active_head_q     <= cur_q;
					init_q[cur_idx]   <= 1'b1;
					active_q[cur_idx] <= 1'b1;
				end
				jsp_pkg::DP_RL_LINK: begin
					if (!link_ok(prev_rd_q)) begin
						active_head_q <= nxt;
					end
					active_q[cur_idx] <= 1'b0;
				end
				jsp_pkg::DP_RL_FREE: begin
					free_head_q <= cur_q;
				end
				jsp_pkg::DP_CLEAR: begin
					init_q        <= '0;
					active_q      <= '0;
					free_head_q   <= '0;
					active_head_q <= jsp_pkg::NULL_LINK;
				end
				default: begin
					free_head_q <= free_head_q;
				end
			endcase
			if (emit_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign slot_out    = slot_q;
	assign tag_out     = tag_out_q;
	assign handler_out = hnd_out_q;
	assign last        = last_q;

endmodule

[design/jsp_checker.sv]
// Port-level checker for the job slot pool, bound to the top level.
// Depends on jsp_pkg for field widths and status codes.
module jsp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_ready,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [jsp_pkg::STAT_W-1:0] rsp_status,
	input logic [jsp_pkg::SLOT_W-1:0] rsp_slot_out,
	input logic [jsp_pkg::TAG_W-1:0]  rsp_tag_out,
	input logic                       rsp_handler_out,
	input logic                       rsp_last
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_slot_out) && $stable(rsp_tag_out) && $stable(rsp_last))
		else $error("response transaction changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while a transaction is in progress");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != jsp_pkg::ST_OK |-> rsp_last)
		else $error("error response not marked last");

	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != jsp_pkg::ST_OK |-> rsp_tag_out == '0 && !rsp_handler_out)
		else $error("error response carries slot data");

endmodule

bind job_slot_pool_with_active_list jsp_checker u_jsp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_slot_out    (rsp.slot_out),
	.rsp_tag_out     (rsp.tag_out),
	.rsp_handler_out (rsp.handler_out),
	.rsp_last        (rsp.last)
);

[verif/tb_job_slot_pool_with_active_list.sv]
// Self-checking testbench for job_slot_pool_with_active_list: random and directed pool traffic.
// A clocked driver and monitor track a predicted free list and active list per transaction.
// Depends on jsp_pkg, jsp_req_if/jsp_rsp_if and the pool top level.
`timescale 1ns / 100ps

module tb_job_slot_pool_with_active_list;

	localparam int SLOTS      = 64;
	localparam int CLK_PERIOD = 8;
	localparam int HOLD_LEN   = 400;
	localparam int RUN_LIMIT  = 1000000;

	typedef struct packed {
		logic [jsp_pkg::OP_W-1:0]   operation;
		logic [jsp_pkg::TAG_W-1:0]  job_tag;
		logic                       has_handler;
		logic [jsp_pkg::SLOT_W-1:0] slot_index;
	} job_req_t;

	typedef struct packed {
		logic [jsp_pkg::STAT_W-1:0] status;
		logic [jsp_pkg::SLOT_W-1:0] slot_out;
		logic [jsp_pkg::TAG_W-1:0]  tag_out;
		logic                       handler_out;
		logic                       last;
	} job_rsp_t;

	logic clk = 1'b0;
	logic arst_n;

	jsp_req_if req();
	jsp_rsp_if rsp();

	job_slot_pool_with_active_list #(
		.POOL_SLOTS(SLOTS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	job_req_t pending_req[$];
	job_rsp_t awaited_rsp[$];
	job_rsp_t want;

	logic [jsp_pkg::LINK_W-1:0] nxt_link[SLOTS];
	logic [jsp_pkg::LINK_W-1:0] prv_link[SLOTS];
	logic [jsp_pkg::TAG_W-1:0]  slot_tag[SLOTS];
	logic                       slot_hnd[SLOTS];
	logic                       slot_live[SLOTS];
	logic [jsp_pkg::LINK_W-1:0] free_hd;
	logic [jsp_pkg::LINK_W-1:0] live_hd;
	int                         live_cnt;

	int send_idle = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_done = 0;
	int hold_left = 0;
	int issued = 0;
	int rsp_seen = 0;
	int fail_cnt = 0;
	int cycles = 0;

	function automatic void rebuild_pool();
		for (int i = 0; i < SLOTS; i++) begin
			nxt_link[i] = (i + 1 < SLOTS) ? jsp_pkg::LINK_W'(i + 1) : jsp_pkg::NULL_LINK;
			prv_link[i] = jsp_pkg::NULL_LINK;
			slot_tag[i] = '0;
			slot_hnd[i] = 1'b0;
			slot_live[i] = 1'b0;
		end
		free_hd = '0;
		live_hd = jsp_pkg::NULL_LINK;
		live_cnt = 0;
	endfunction

	function automatic void queue_rsp(logic [jsp_pkg::STAT_W-1:0] st,
	                                  logic [jsp_pkg::LINK_W-1:0] slot,
	                                  logic [jsp_pkg::TAG_W-1:0] tag, logic hnd, logic fin);
		job_rsp_t r;
		r.status = st;
		r.slot_out = slot[jsp_pkg::SLOT_W-1:0];
		r.tag_out = tag;
		r.handler_out = hnd;
		r.last = fin;
		awaited_rsp.push_back(r);
	endfunction

	function automatic void advance_pool(job_req_t r);
		logic [jsp_pkg::LINK_W-1:0] s;
		logic [jsp_pkg::LINK_W-1:0] p;
		logic [jsp_pkg::LINK_W-1:0] n;
		int k;
		case (r.operation)
			jsp_pkg::OP_ALLOC: begin
				s = free_hd;
				if (s >= SLOTS) begin
					queue_rsp(jsp_pkg::ST_FULL, '0, '0, 1'b0, 1'b1);
				end else begin
					free_hd = nxt_link[s];
					slot_tag[s] = r.job_tag;
					slot_hnd[s] = r.has_handler;
					slot_live[s] = 1'b1;
					nxt_link[s] = live_hd;
					prv_link[s] = jsp_pkg::NULL_LINK;
					if (live_hd < SLOTS)
						prv_link[live_hd] = s;
					live_hd = s;
					live_cnt++;
					queue_rsp(jsp_pkg::ST_OK, s, '0, 1'b0, 1'b1);
				end
			end
			jsp_pkg::OP_RELEASE: begin
				s = jsp_pkg::LINK_W'(r.slot_index);
				if (s >= SLOTS || !slot_live[s]) begin
					queue_rsp(jsp_pkg::ST_NOT_ACTIVE, s, '0, 1'b0, 1'b1);
				end else begin
					p = prv_link[s];
					n = nxt_link[s];
					if (p < SLOTS)
						nxt_link[p] = n;
					else
						live_hd = n;
					if (n < SLOTS)
						prv_link[n] = p;
					prv_link[s] = jsp_pkg::NULL_LINK;
					nxt_link[s] = free_hd;
					slot_tag[s] = '0;
					slot_hnd[s] = 1'b0;
					slot_live[s] = 1'b0;
					free_hd = s;
					live_cnt--;
					queue_rsp(jsp_pkg::ST_OK, s, '0, 1'b0, 1'b1);
				end
			end
			jsp_pkg::OP_WALK: begin
				s = live_hd;
				k = 0;
				if (s >= SLOTS)
					queue_rsp(jsp_pkg::ST_EMPTY, '0, '0, 1'b0, 1'b1);
				while (s < SLOTS && k < SLOTS) begin
					n = nxt_link[s];
					queue_rsp(jsp_pkg::ST_OK, s, slot_tag[s], slot_hnd[s],
					          n >= SLOTS || k + 1 >= SLOTS);
					k++;
					s = n;
				end
			end
			default: begin
				rebuild_pool();
				queue_rsp(jsp_pkg::ST_OK, '0, '0, 1'b0, 1'b1);
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
	                               input longint unsigned exp_val);
		$display("[%0t] response %0d: %s got 0x%0h expected 0x%0h",
		         $time, rsp_seen, what, got, exp_val);
		fail_cnt++;
	endtask

	// driver: hold an offered transaction until it is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				advance_pool(pending_req[0]);
				pending_req.pop_front();
			end
			if (!(req.valid && !req.ready)) begin
				if (pending_req.size() != 0 && $urandom_range(99) >= send_idle) begin
					req.valid <= 1'b1;
					req.operation <= pending_req[0].operation;
					req.job_tag <= pending_req[0].job_tag;
					req.has_handler <= pending_req[0].has_handler;
					req.slot_index <= pending_req[0].slot_index;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp.ready <= 1'b0;
		end else if (hold_asked != hold_done) begin
			hold_done <= hold_done + 1;
			hold_left <= HOLD_LEN;
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (awaited_rsp.size() == 0) begin
				report_mismatch("transaction with nothing pending, slot", 64'(rsp.slot_out),
				                64'd0);
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.status !== want.status)
					report_mismatch("status", 64'(rsp.status), 64'(want.status));
				if (rsp.slot_out !== want.slot_out)
					report_mismatch("slot_out", 64'(rsp.slot_out), 64'(want.slot_out));
				if (rsp.tag_out !== want.tag_out)
					report_mismatch("tag_out", 64'(rsp.tag_out), 64'(want.tag_out));
				if (rsp.handler_out !== want.handler_out)
					report_mismatch("handler_out", 64'(rsp.handler_out),
					                64'(want.handler_out));
				if (rsp.last !== want.last)
					report_mismatch("last", 64'(rsp.last), 64'(want.last));
			end
			rsp_seen++;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic offer(input logic [jsp_pkg::OP_W-1:0] op,
	                     input logic [jsp_pkg::TAG_W-1:0] tag,
	                     input logic hnd, input logic [jsp_pkg::SLOT_W-1:0] idx);
		job_req_t r;
		r.operation = op;
		r.job_tag = tag;
		r.has_handler = hnd;
		r.slot_index = idx;
		pending_req.push_back(r);
		issued++;
	endtask

	task automatic drain_requests();
		while (pending_req.size() != 0)
			@(negedge clk);
	endtask

	function automatic void list_active(output logic [jsp_pkg::SLOT_W-1:0] order[$]);
		logic [jsp_pkg::LINK_W-1:0] s;
		order = {};
		s = live_hd;
		while (s < SLOTS && order.size() < SLOTS) begin
			order.push_back(s[jsp_pkg::SLOT_W-1:0]);
			s = nxt_link[s];
		end
	endfunction

	task automatic fill_pool();
		int n;
		n = SLOTS - live_cnt + 1 + $urandom_range(1);
		repeat (n)
			offer(jsp_pkg::OP_ALLOC, $urandom, 1'($urandom_range(1)),
			      jsp_pkg::SLOT_W'($urandom_range(63)));
	endtask

	task automatic run_batch();
		logic [jsp_pkg::SLOT_W-1:0] order[$];
		logic [jsp_pkg::SLOT_W-1:0] tmp;
		int kind;
		int k;
		int j;
		kind = $urandom_range(99);
		list_active(order);
		if (kind < 30) begin
			repeat ($urandom_range(8, 1))
				offer(jsp_pkg::OP_ALLOC, $urandom, 1'($urandom_range(1)),
				      jsp_pkg::SLOT_W'($urandom_range(63)));
		end else if (kind < 55) begin
			offer(jsp_pkg::OP_WALK, $urandom, 1'($urandom_range(1)),
			      jsp_pkg::SLOT_W'($urandom_range(63)));
			if (order.size() != 0) begin
				k = $urandom_range(order.size(), 1);
				for (int i = 0; i < k; i++)
					offer(jsp_pkg::OP_RELEASE, $urandom, 1'($urandom_range(1)), order[i]);
			end
		end else if (kind < 75) begin
			for (int i = order.size() - 1; i > 0; i--) begin
				j = $urandom_range(i);
				tmp = order[i];
				order[i] = order[j];
				order[j] = tmp;
			end
			if (order.size() != 0) begin
				k = $urandom_range(order.size(), 1);
				for (int i = 0; i < k; i++)
					offer(jsp_pkg::OP_RELEASE, $urandom, 1'($urandom_range(1)), order[i]);
			end
		end else if (kind < 78) begin
			fill_pool();
		end else begin
			repeat ($urandom_range(4, 1)) begin
				case ($urandom_range(3))
					0: offer(jsp_pkg::OP_ALLOC, $urandom, 1'($urandom_range(1)),
					         jsp_pkg::SLOT_W'($urandom_range(63)));
					1: offer(jsp_pkg::OP_RELEASE, $urandom, 1'($urandom_range(1)),
					         jsp_pkg::SLOT_W'($urandom_range(63)));
					2: offer(jsp_pkg::OP_WALK, $urandom, 1'($urandom_range(1)),
					         jsp_pkg::SLOT_W'($urandom_range(63)));
					default: begin
						if ($urandom_range(9) == 0)
							offer(jsp_pkg::OP_CLEAR, $urandom, 1'($urandom_range(1)),
							      jsp_pkg::SLOT_W'($urandom_range(63)));
						else
							offer(jsp_pkg::OP_WALK, $urandom, 1'($urandom_range(1)),
							      jsp_pkg::SLOT_W'($urandom_range(63)));
					end
				endcase
			end
		end
		drain_requests();
	endtask

	task automatic run_phase(input int idle, input int stall, input int count);
		int goal;
		@(negedge clk);
		send_idle = idle;
		stall_pct = stall;
		goal = issued + count;
		while (issued < goal)
			run_batch();
	endtask

	initial begin
		req.valid = 1'b0;
		req.operation = jsp_pkg::OP_ALLOC;
		req.job_tag = '0;
		req.has_handler = 1'b0;
		req.slot_index = '0;
		rsp.ready = 1'b0;
		arst_n = 1'b0;
		rebuild_pool();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		offer(jsp_pkg::OP_WALK, '0, 1'b0, '0);
		offer(jsp_pkg::OP_RELEASE, '0, 1'b0, 6'd0);
		offer(jsp_pkg::OP_RELEASE, '1, 1'b1, 6'd63);
		offer(jsp_pkg::OP_ALLOC, 32'h0000_0000, 1'b0, '0);
		offer(jsp_pkg::OP_ALLOC, 32'hFFFF_FFFF, 1'b1, '1);
		offer(jsp_pkg::OP_ALLOC, 32'hA5A5_5A5A, 1'b1, '0);
		offer(jsp_pkg::OP_ALLOC, 32'h1234_5678, 1'b0, '0);
		offer(jsp_pkg::OP_WALK, '0, 1'b0, '0);
		offer(jsp_pkg::OP_RELEASE, '0, 1'b0, 6'd1);
		offer(jsp_pkg::OP_WALK, '0, 1'b0, '0);
		offer(jsp_pkg::OP_RELEASE, '0, 1'b0, 6'd3);
		offer(jsp_pkg::OP_RELEASE, '0, 1'b0, 6'd0);
		offer(jsp_pkg::OP_WALK, '0, 1'b0, '0);
		offer(jsp_pkg::OP_RELEASE, '0, 1'b0, 6'd2);
		offer(jsp_pkg::OP_WALK, '0, 1'b0, '0);
		offer(jsp_pkg::OP_RELEASE, '0, 1'b0, 6'd2);
		offer(jsp_pkg::OP_ALLOC, 32'hDEAD_BEEF, 1'b1, '0);
		offer(jsp_pkg::OP_ALLOC, 32'h0F0F_0F0F, 1'b0, '0);
		offer(jsp_pkg::OP_CLEAR, '0, 1'b0, '0);
		offer(jsp_pkg::OP_WALK, '0, 1'b0, '0);
		offer(jsp_pkg::OP_ALLOC, 32'h8000_0001, 1'b1, '0);
		drain_requests();

		run_phase(0, 0, 90);

		// hold off the receiver while the pool fills to overflow
		@(negedge clk);
		hold_asked = hold_asked + 1;
		fill_pool();
		offer(jsp_pkg::OP_WALK, $urandom, 1'b1, '1);
		offer(jsp_pkg::OP_RELEASE, $urandom, 1'b0, 6'd63);
		offer(jsp_pkg::OP_WALK, $urandom, 1'b0, '0);
		offer(jsp_pkg::OP_CLEAR, $urandom, 1'b1, '1);
		drain_requests();

		run_phase(60, 0, 90);
		run_phase(0, 60, 90);
		run_phase(33, 33, 90);

		drain_requests();
		while (awaited_rsp.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[filelist.f]
design/jsp_pkg.sv
design/jsp_if.sv
design/jsp_ctrl.sv
design/jsp_dp.sv
design/job_slot_pool_with_active_list.sv
design/jsp_checker.sv
verif/tb_job_slot_pool_with_active_list.sv
